// ===== hw/rtl/ofm_pkg.sv =====
// Shared types and constants for the order-1 byte frequency model.
// No dependencies; used by ofm_seq and the top level.
package ofm_pkg;

  localparam int SYM_W = 8;
  localparam int CNT_W = 16;
  localparam int TOT_W = 24;
  localparam int STAT_W = 32;
  localparam int SLOT_W = 2 * SYM_W;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 16'hFFFE;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
  localparam logic [STAT_W-1:0] STAT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_HALVE,
    ST_HALVE_LAST,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [STAT_W-1:0] tried;
    logic [STAT_W-1:0] matched;
  } ctx_t;

  typedef struct packed {
    logic context_valid;
    logic [CNT_W-1:0] symbol_count;
    logic [TOT_W-1:0] context_total;
    logic [STAT_W-1:0] tried_count;
    logic [STAT_W-1:0] matched_count;
  } res_t;

endpackage

// ===== hw/rtl/ofm_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ofm_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/ofm_seq.sv =====
// Sequencer and datapath: clearing pass, read-modify-write of the counters,
// rescale walk with the shared halve/accumulate unit. Uses ofm_pkg, ofm_ram.
module ofm_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ofm_pkg::SYM_W-1:0]   data_byte,
  input  logic                        restart,
  input  logic [ofm_pkg::CNT_W-1:0]   rescale_limit,
  output ofm_pkg::res_t               res,
  output logic                        res_valid,
  input  logic                        res_ready
);

  ofm_pkg::state_t state, state_next;

  logic [ofm_pkg::SLOT_W-1:0] clr_idx;
  logic                       have_prev;
  logic [ofm_pkg::SYM_W-1:0]  prev;
  logic [ofm_pkg::SYM_W-1:0]  ctx;
  logic [ofm_pkg::SYM_W-1:0]  sym;
  logic [ofm_pkg::CNT_W-1:0]  cnt;
  logic [ofm_pkg::TOT_W-1:0]  tot;
  logic [ofm_pkg::STAT_W-1:0] tried_n;
  logic [ofm_pkg::STAT_W-1:0] matched_n;
  logic [ofm_pkg::SYM_W-1:0]  idx;
  logic                       wb;
  logic [ofm_pkg::SYM_W-1:0]  wb_idx;
  logic [ofm_pkg::TOT_W-1:0]  sum;

  logic                       sym_we;
  logic [ofm_pkg::SLOT_W-1:0] sym_waddr;
  logic [ofm_pkg::CNT_W-1:0]  sym_wdata;
  logic [ofm_pkg::SLOT_W-1:0] sym_raddr;
  logic [ofm_pkg::CNT_W-1:0]  sym_rdata;

  logic                       ctx_we;
  logic [ofm_pkg::SYM_W-1:0]  ctx_waddr;
  ofm_pkg::ctx_t              ctx_wdata;
  logic [$bits(ofm_pkg::ctx_t)-1:0] ctx_rraw;
  ofm_pkg::ctx_t              ctx_rd;

  logic [ofm_pkg::CNT_W-1:0]  half;
  logic [ofm_pkg::CNT_W-1:0]  cnt_half;
  logic                       cnt_inc;
  logic                       accept;

  assign ctx_rd   = ofm_pkg::ctx_t'(ctx_rraw);
  assign half     = ofm_pkg::CNT_W'(({1'b0, sym_rdata} + 17'd1) >> 1);
  assign cnt_half = ofm_pkg::CNT_W'(({1'b0, cnt} + 17'd1) >> 1);
  assign cnt_inc  = (cnt != ofm_pkg::CNT_MAX);
  assign accept   = in_valid && in_ready;

  ofm_ram #(.ADDR_W(ofm_pkg::SLOT_W), .DATA_W(ofm_pkg::CNT_W)) u_sym_ram (
    .clk     (clk),
    .wr_en   (sym_we),
    .wr_addr (sym_waddr),
    .wr_data (sym_wdata),
    .rd_addr (sym_raddr),
    .rd_data (sym_rdata)
  );

  ofm_ram #(.ADDR_W(ofm_pkg::SYM_W), .DATA_W($bits(ofm_pkg::ctx_t))) u_ctx_ram (
    .clk     (clk),
    .wr_en   (ctx_we),
    .wr_addr (ctx_waddr),
    .wr_data (ctx_wdata),
    .rd_addr (ctx),
    .rd_data (ctx_rraw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ofm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    sym_we     = 1'b0;
    sym_waddr  = {ctx, sym};
    sym_wdata  = '0;
    sym_raddr  = {ctx, sym};
    ctx_we     = 1'b0;
    ctx_waddr  = ctx;
    ctx_wdata  = '0;
    case (state)
      ofm_pkg::ST_CLEAR: begin
        sym_we    = 1'b1;
        sym_waddr = clr_idx;
        ctx_we    = 1'b1;
        ctx_waddr = clr_idx[ofm_pkg::SYM_W-1:0];
        if (clr_idx == '1) begin
          state_next = ofm_pkg::ST_IDLE;
        end
      end
      ofm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (restart || !have_prev) ? ofm_pkg::ST_OUT : ofm_pkg::ST_READ;
        end
      end
      ofm_pkg::ST_READ: begin
        state_next = ofm_pkg::ST_CALC;
      end
      ofm_pkg::ST_CALC: begin
        state_next = (sym_rdata >= rescale_limit) ? ofm_pkg::ST_HALVE : ofm_pkg::ST_UPDATE;
      end
      ofm_pkg::ST_HALVE: begin
        sym_raddr = {ctx, idx};
        sym_we    = wb;
        sym_waddr = {ctx, wb_idx};
        sym_wdata = half;
        if (idx == '1) begin
          state_next = ofm_pkg::ST_HALVE_LAST;
        end
      end
      ofm_pkg::ST_HALVE_LAST: begin
        sym_we     = 1'b1;
        sym_waddr  = {ctx, wb_idx};
        sym_wdata  = half;
        state_next = ofm_pkg::ST_UPDATE;
      end
      ofm_pkg::ST_UPDATE: begin
        sym_we    = cnt_inc;
        sym_wdata = cnt + 16'd1;
        ctx_we    = 1'b1;
        ctx_wdata = '{total: cnt_inc ? tot + 24'd1 : tot, tried: tried_n, matched: matched_n};
        state_next = ofm_pkg::ST_OUT;
      end
      ofm_pkg::ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ofm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ofm_pkg::ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      have_prev <= 1'b0;
      prev      <= '0;
      wb        <= 1'b0;
    end else begin
      if (state == ofm_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 16'd1;
      end
      if (accept) begin
        have_prev <= 1'b1;
        prev      <= data_byte;
      end
      if (state == ofm_pkg::ST_CALC) begin
        wb <= 1'b0;
      end else if (state == ofm_pkg::ST_HALVE) begin
        wb <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ofm_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctx <= prev;
          sym <= data_byte;
          res <= '0;
        end
      end
      ofm_pkg::ST_CALC: begin
        res <= '{context_valid: (ctx_rd.tried != '0),
                 symbol_count:  sym_rdata,
                 context_total: ctx_rd.total,
                 tried_count:   ctx_rd.tried,
                 matched_count: ctx_rd.matched};
        cnt       <= sym_rdata;
        tot       <= ctx_rd.total;
        tried_n   <= (ctx_rd.tried != ofm_pkg::STAT_MAX) ? ctx_rd.tried + 32'd1 : ctx_rd.tried;
        matched_n <= (sym_rdata != '0 && ctx_rd.matched != ofm_pkg::STAT_MAX)
                     ? ctx_rd.matched + 32'd1 : ctx_rd.matched;
        idx       <= '0;
        sum       <= '0;
      end
      ofm_pkg::ST_HALVE: begin
        idx    <= idx + 8'd1;
        wb_idx <= idx;
        if (wb) begin
          sum <= sum + ofm_pkg::TOT_W'(half);
        end
      end
      ofm_pkg::ST_HALVE_LAST: begin
        tot <= sum + ofm_pkg::TOT_W'(half);
        cnt <= cnt_half;
      end
      default: begin
      end
    endcase
  end

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready not dropped after request");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ofm_pkg::ST_HALVE && idx == '1) |=> state == ofm_pkg::ST_HALVE_LAST)
    else $error("rescale walk overran");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while held");

  a_tried_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ofm_pkg::ST_UPDATE) |-> ctx_wdata.tried != '0)
    else $error("tried count written as zero");

endmodule

// ===== hw/rtl/order1_byte_frequency_model_top.sv =====
// Top level of the order-1 byte frequency model: limit register, result
// register, and the sequencer. Uses ofm_pkg and ofm_seq.
//
// Usage:
//   Input channel in_valid/in_ready carries data_byte and restart. Output
//   channel out_valid/out_ready carries the statistics of (previous byte,
//   byte) as they stood before the update. Configuration channel
//   cfg_valid/cfg_ready writes rescale_limit from cfg_data; it is always
//   ready, also during the clearing pass.
//   After reset the block walks the whole counter memory once to clear it,
//   all 65536 counters, with in_ready low. rescale_limit resets to 0xFFFE.
//   Per item: a byte with no context goes from request straight to result
//   handoff; a normal byte passes a memory read, a compare and one
//   read-modify-write. A rescale adds a walk by the halving unit over
//   the 256 counters of the context through one memory port.
//   One item is in flight at a time; in_ready returns once the result has
//   moved into the output register, so one result can wait there while
//   the next request is processed. If the receiver stalls with a result
//   already waiting, the next item holds in the sequencer until it drains.
module order1_byte_frequency_model_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ofm_pkg::SYM_W-1:0]    data_byte,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         context_valid,
  output logic [ofm_pkg::CNT_W-1:0]    symbol_count,
  output logic [ofm_pkg::TOT_W-1:0]    context_total,
  output logic [ofm_pkg::STAT_W-1:0]   tried_count,
  output logic [ofm_pkg::STAT_W-1:0]   matched_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ofm_pkg::CNT_W-1:0]    cfg_data
);

  logic [ofm_pkg::CNT_W-1:0] rescale_limit;
  ofm_pkg::res_t             res;
  logic                      res_valid;
  logic                      res_ready;
  ofm_pkg::res_t             out_reg;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rescale_limit <= ofm_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rescale_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_reg <= res;
    end
  end

  assign context_valid = out_reg.context_valid;
  assign symbol_count  = out_reg.symbol_count;
  assign context_total = out_reg.context_total;
  assign tried_count   = out_reg.tried_count;
  assign matched_count = out_reg.matched_count;

  ofm_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .restart       (restart),
    .rescale_limit (rescale_limit),
    .res           (res),
    .res_valid     (res_valid),
    .res_ready     (res_ready)
  );

endmodule
